/* rtl/core/jakes_fading_oscillator_bank_top_defines.svh */
// Assertion helpers for the fading oscillator bank.
// Both sample on the rising clock edge and are off while reset is high.
`ifndef JAKES_FADING_OSCILLATOR_BANK_TOP_DEFINES_SVH
`define JAKES_FADING_OSCILLATOR_BANK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JFOB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JFOB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/jfob_pkg.sv */
package jfob_pkg;

   localparam int OSC_COUNT   = 8;
   localparam int LINKS       = 16;
   localparam int PHASE_BITS  = 16;
   localparam int OSC_SLOTS   = OSC_COUNT + 1;
   localparam int PHASE_DEPTH = LINKS * OSC_SLOTS;
   localparam int PHASE_AW    = $clog2(PHASE_DEPTH);
   localparam int LINK_AW     = $clog2(LINKS);
   localparam int OSC_AW      = $clog2(OSC_SLOTS);
   localparam int LINK_W      = 4;
   localparam int OSC_W       = 4;
   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 24;
   localparam int OUT_W       = 16;
   localparam int TERMS       = 7;
   localparam int TERM_AW     = 3;
   localparam int INC_SH      = 54 - PHASE_BITS;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam int          DB_PER_LOG2 = 197283;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_STEP   = 2'd0,
      CMD_LOAD_PHASE = 2'd1,
      CMD_ADVANCE    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic signed [63:0] c;
      logic signed [63:0] s;
   } cs_type;

   typedef logic [OSC_SLOTS-1:0][31:0] osc_tab_type;
   typedef logic [TERMS:0][31:0]       term_tab_type;

   // elaboration-time helpers for the constant tables
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = val;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic cs_type taylor(input logic [31:0] t);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] tc;
      logic [63:0] ts;
      cs_type      r;
      x   = (64'(t) * PI_Q30) >> 31;
      x2  = (x * x) >> 30;
      tc  = 64'd1 << 30;
      ts  = x;
      r.c = $signed(tc);
      r.s = $signed(ts);
      for (int n = 1; n <= TERMS; n++) begin
         tc = udiv64((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
         ts = udiv64((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
         if (n % 2 == 1) begin
            r.c = r.c - $signed(tc);
            r.s = r.s - $signed(ts);
         end else begin
            r.c = r.c + $signed(tc);
            r.s = r.s + $signed(ts);
         end
      end
      return r;
   endfunction

   function automatic cs_type sincos(input logic [31:0] a);
      logic [29:0] rr;
      cs_type      t;
      cs_type      f;
      cs_type      r;
      rr = a[29:0];
      if ({2'b00, rr} <= 32'h2000_0000) begin
         f = taylor({2'b00, rr});
      end else begin
         t   = taylor(32'h4000_0000 - {2'b00, rr});
         f.c = t.s;
         f.s = t.c;
      end
      unique case (a[31:30])
         2'd0: begin r.c = f.c;  r.s = f.s;  end
         2'd1: begin r.c = -f.s; r.s = f.c;  end
         2'd2: begin r.c = -f.c; r.s = -f.s; end
         default: begin r.c = f.s; r.s = -f.c; end
      endcase
      return r;
   endfunction

   function automatic osc_tab_type build_inc_mag();
      osc_tab_type        tab;
      logic        [63:0] ang;
      cs_type             cs;
      logic signed [63:0] m;
      for (int k = 0; k < OSC_SLOTS; k++) begin
         ang    = udiv64(64'(k) << 32, 64'(4 * OSC_COUNT + 2));
         cs     = sincos(ang[31:0]);
         m      = (cs.c < 0) ? -cs.c : cs.c;
         tab[k] = m[31:0];
      end
      return tab;
   endfunction

   function automatic logic [OSC_SLOTS-1:0] build_inc_neg();
      logic [OSC_SLOTS-1:0] tab;
      logic [63:0]          ang;
      cs_type               cs;
      for (int k = 0; k < OSC_SLOTS; k++) begin
         ang    = udiv64(64'(k) << 32, 64'(4 * OSC_COUNT + 2));
         cs     = sincos(ang[31:0]);
         tab[k] = (cs.c < 0);
      end
      return tab;
   endfunction

   function automatic osc_tab_type build_coef(input logic is_q);
      osc_tab_type        tab;
      logic        [63:0] sq_i;
      logic        [63:0] sq_q;
      logic        [63:0] sq_0;
      logic        [63:0] ang;
      logic        [63:0] quo;
      cs_type             cs;
      logic signed [63:0] val;
      logic signed [63:0] m;
      sq_i = isqrt64(64'(2 * OSC_COUNT) << 56);
      sq_q = isqrt64(64'(2 * OSC_COUNT + 2) << 56);
      sq_0 = isqrt64(64'(OSC_COUNT) << 56);
      for (int k = 0; k < OSC_SLOTS; k++) begin
         if (k == 0) begin
            quo    = is_q ? 64'd0 : udiv64(64'd1 << 58, sq_0);
            tab[k] = quo[31:0];
         end else begin
            ang    = udiv64(64'(k) << 32, 64'(2 * OSC_COUNT));
            cs     = sincos(ang[31:0]);
            val    = is_q ? cs.s : cs.c;
            m      = (val < 0) ? -val : val;
            quo    = udiv64($unsigned(m) << 29, is_q ? sq_q : sq_i);
            quo    = (val < 0) ? (64'd0 - quo) : quo;
            tab[k] = quo[31:0];
         end
      end
      return tab;
   endfunction

   function automatic term_tab_type build_div(input logic is_sin);
      term_tab_type tab;
      tab[0] = 32'd1;
      for (int n = 1; n <= TERMS; n++) begin
         tab[n] = is_sin ? 32'((2 * n) * (2 * n + 1)) : 32'((2 * n - 1) * (2 * n));
      end
      return tab;
   endfunction

   function automatic term_tab_type build_rec(input logic is_sin);
      term_tab_type tab;
      term_tab_type dv;
      logic [63:0]  quo;
      dv = build_div(is_sin);
      for (int n = 0; n <= TERMS; n++) begin
         quo    = udiv64(64'd1 << 31, 64'(dv[n]));
         tab[n] = quo[31:0];
      end
      return tab;
   endfunction

   localparam osc_tab_type          INC_MAG = build_inc_mag();
   localparam logic [OSC_SLOTS-1:0] INC_NEG = build_inc_neg();
   localparam osc_tab_type          COEF_I  = build_coef(1'b0);
   localparam osc_tab_type          COEF_Q  = build_coef(1'b1);
   localparam term_tab_type         DIV_COS = build_div(1'b0);
   localparam term_tab_type         DIV_SIN = build_div(1'b1);
   localparam term_tab_type         REC_COS = build_rec(1'b0);
   localparam term_tab_type         REC_SIN = build_rec(1'b1);

endpackage

/* rtl/core/jfob_req_if.sv */
interface jfob_req_if;
   logic                             valid;
   logic                             ready;
   logic [jfob_pkg::CMD_W-1:0]       command;
   logic [jfob_pkg::LINK_W-1:0]      link;
   logic [jfob_pkg::OSC_W-1:0]       oscillator;
   logic [jfob_pkg::VALUE_W-1:0]     value;

   modport source (output valid, command, link, oscillator, value, input ready);
   modport sink   (input valid, command, link, oscillator, value, output ready);
endinterface

/* rtl/core/jfob_rsp_if.sv */
interface jfob_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [jfob_pkg::OUT_W-1:0] in_phase;
   logic signed [jfob_pkg::OUT_W-1:0] quadrature;
   logic signed [jfob_pkg::OUT_W-1:0] power_db;
   logic [jfob_pkg::LINK_W-1:0]       link_out;

   modport source (output valid, in_phase, quadrature, power_db, link_out, input ready);
   modport sink   (input valid, in_phase, quadrature, power_db, link_out, output ready);
endinterface

/* rtl/core/jakes_fading_oscillator_bank_top.sv */
// Set-step and load-phase beats: taken while idle, no result beat.
// Advance beat: each of the 9 oscillators in turn through the one shared
// 34x34 multiplier, then rounding and power, log normalisation,
// 16 squaring steps, then dB and output load; at zero power the normalisation,
// log and dB steps are skipped. The result beat waits in the output state
// while the previous result beat is still held by the sink.
// One beat at a time; the result sits in an output register while the next is taken.
// Synchronous reset clears phases (per-entry valid bits) and Doppler steps at once.
`include "jakes_fading_oscillator_bank_top_defines.svh"

module jakes_fading_oscillator_bank_top (
   input logic          clock,
   input logic          reset,
   jfob_req_if.sink     req_ch,
   jfob_rsp_if.source   rsp_ch
);

   typedef enum logic [17:0] {
      ST_IDLE = 18'h00001,
      ST_RD   = 18'h00002,
      ST_INC  = 18'h00004,
      ST_X    = 18'h00008,
      ST_X2   = 18'h00010,
      ST_T1   = 18'h00020,
      ST_T2   = 18'h00040,
      ST_T3   = 18'h00080,
      ST_ACC  = 18'h00100,
      ST_AI   = 18'h00200,
      ST_AQ   = 18'h00400,
      ST_RND  = 18'h00800,
      ST_P1   = 18'h01000,
      ST_P2   = 18'h02000,
      ST_NORM = 18'h04000,
      ST_LOG  = 18'h08000,
      ST_DB   = 18'h10000,
      ST_OUT  = 18'h20000
   } state_type;

   localparam int PB = jfob_pkg::PHASE_BITS;
   localparam int AW = jfob_pkg::PHASE_AW;
   localparam logic [jfob_pkg::TERM_AW-1:0] TERM_ONE = jfob_pkg::TERM_AW'(1);

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767)       r = 16'sh7fff;
      else if (v < -24'sd32768) r = 16'sh8000;
      else                      r = v[15:0];
      return r;
   endfunction

   // sequencer state
   state_type                           state_ff, state_in;
   logic [jfob_pkg::LINK_W-1:0]         link_ff, link_in;
   logic [jfob_pkg::OSC_AW-1:0]         k_ff, k_in;
   logic [jfob_pkg::TERM_AW-1:0]        n_ff, n_in;
   logic                                use_sin_ff, use_sin_in;
   logic                                neg_ff, neg_in;
   logic [29:0]                         x2_ff, x2_in;
   logic [29:0]                         v_ff, v_in;
   logic [29:0]                         q_ff, q_in;
   logic signed [32:0]                  sum_ff, sum_in;
   logic signed [32:0]                  cp_ff, cp_in;
   logic signed [35:0]                  acc_i_ff, acc_i_in;
   logic signed [35:0]                  acc_q_ff, acc_q_in;
   logic signed [15:0]                  iv_ff, iv_in;
   logic signed [15:0]                  qv_ff, qv_in;
   logic [31:0]                         p1_ff, p1_in;
   logic [30:0]                         m_ff, m_in;
   logic [4:0]                          e_ff, e_in;
   logic [3:0]                          b_ff, b_in;
   logic [15:0]                         frac_ff, frac_in;
   logic signed [15:0]                  db_ff, db_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]                  rsp_i_ff, rsp_i_in;
   logic signed [15:0]                  rsp_q_ff, rsp_q_in;
   logic signed [15:0]                  rsp_db_ff, rsp_db_in;
   logic [jfob_pkg::LINK_W-1:0]         rsp_link_ff, rsp_link_in;

   // shared multiplier: operands picked by state, product registered
   logic signed [33:0]                  mul_a, mul_b;
   logic signed [67:0]                  mul_p_ff;

   // phase store and Doppler steps
   logic [PB-1:0]                       phase_mem [jfob_pkg::PHASE_DEPTH];
   logic [jfob_pkg::PHASE_DEPTH-1:0]    ph_vld_ff;
   logic [PB-1:0]                       ph_rd_ff;
   logic                                ph_rd_vld_ff;
   logic [jfob_pkg::VALUE_W-1:0]        step_ff [jfob_pkg::LINKS];

   logic                                req_fire;
   logic                                req_link_ok;
   logic                                load_we;
   logic                                step_we;
   logic                                mem_we;
   logic [AW-1:0]                       rd_addr, req_addr, mem_wa;
   logic [PB-1:0]                       mem_wd;

   // datapath taps
   logic [jfob_pkg::VALUE_W-1:0]        step_cur;
   logic [55:0]                         inc_r;
   logic [PB-1:0]                       inc_v, ph_old, ph_new;
   logic [31:0]                         ang;
   logic                                ang_big;
   logic [30:0]                         t_arg;
   logic [29:0]                         x_tap, x2_tap, v_tap, q_tap, qd_tap, rem;
   logic [30:0]                         term_init, term_new;
   logic [31:0]                         div_sel, rec_sel;
   logic signed [32:0]                  cp_tap;
   logic signed [36:0]                  rnd_i, rnd_q;
   logic [31:0]                         p_sum;
   logic [31:0]                         m2;
   logic [30:0]                         m_new;
   logic [15:0]                         frac_new;
   logic [6:0]                          e_rel;
   logic signed [22:0]                  lg;
   logic signed [47:0]                  db_r;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_link_ok  = (32'(req_ch.link) < jfob_pkg::LINKS);
   assign step_we      = req_fire && req_link_ok
                         && (req_ch.command == jfob_pkg::CMD_SET_STEP);
   assign load_we      = req_fire && req_link_ok
                         && (req_ch.command == jfob_pkg::CMD_LOAD_PHASE)
                         && (32'(req_ch.oscillator) <= jfob_pkg::OSC_COUNT);

   assign rd_addr  = AW'(link_ff) * AW'(jfob_pkg::OSC_SLOTS) + AW'(k_ff);
   assign req_addr = AW'(req_ch.link) * AW'(jfob_pkg::OSC_SLOTS) + AW'(req_ch.oscillator);
   assign mem_we   = load_we || (state_ff == ST_INC);
   assign mem_wa   = (state_ff == ST_INC) ? rd_addr : req_addr;
   assign mem_wd   = (state_ff == ST_INC) ? ph_new : req_ch.value[PB-1:0];

   assign step_cur = step_ff[link_ff[jfob_pkg::LINK_AW-1:0]];

   // phase update: round step*|cos| to phase LSBs, wrap modulo one turn
   assign inc_r  = mul_p_ff[55:0] + (56'd1 << (jfob_pkg::INC_SH - 1));
   assign inc_v  = inc_r[jfob_pkg::INC_SH +: PB];
   assign ph_old = ph_rd_vld_ff ? ph_rd_ff : '0;
   assign ph_new = jfob_pkg::INC_NEG[k_ff] ? (ph_old - inc_v) : (ph_old + inc_v);

   // fold to an eighth of a turn; pick cos or sin series and final sign
   assign ang     = 32'(ph_new) << (32 - PB);
   assign ang_big = (ang[29:0] > 30'h2000_0000);
   assign t_arg   = ang_big ? (31'h4000_0000 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};

   assign x_tap   = mul_p_ff[60:31];
   assign x2_tap  = mul_p_ff[59:30];
   assign v_tap   = mul_p_ff[59:30];
   assign q_tap   = mul_p_ff[60:31];
   assign qd_tap  = mul_p_ff[29:0];
   assign term_init = use_sin_ff ? {1'b0, v_ff} : 31'h4000_0000;

   assign div_sel  = use_sin_ff ? jfob_pkg::DIV_SIN[n_ff] : jfob_pkg::DIV_COS[n_ff];
   assign rec_sel  = use_sin_ff ? jfob_pkg::REC_SIN[n_ff] : jfob_pkg::REC_COS[n_ff];
   assign rem      = v_ff - qd_tap;
   assign term_new = (32'(rem) >= div_sel) ? (31'(q_ff) + 31'd1) : 31'(q_ff);
   assign cp_tap   = neg_ff ? -sum_ff : sum_ff;

   assign rnd_i = 37'(acc_i_ff) + 37'sd262144;
   assign rnd_q = 37'(acc_q_ff) + 37'sd262144;
   assign p_sum = p1_ff + mul_p_ff[31:0];

   // log2 fraction: square, one bit per step
   assign m2       = mul_p_ff[61:30];
   assign m_new    = m2[31] ? m2[31:1] : m2[30:0];
   assign frac_new = {frac_ff[14:0], m2[31]};
   assign e_rel    = {2'b00, e_ff} - 7'd22;
   assign lg       = $signed({e_rel, frac_new});
   assign db_r     = mul_p_ff[47:0] + 48'sd8388608;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RD: begin
            mul_a = $signed(34'(step_cur));
            mul_b = $signed(34'(jfob_pkg::INC_MAG[k_ff]));
         end
         ST_INC: begin
            mul_a = $signed(34'(t_arg));
            mul_b = $signed(34'(jfob_pkg::PI_Q30[31:0]));
         end
         ST_X: begin
            mul_a = $signed(34'(x_tap));
            mul_b = $signed(34'(x_tap));
         end
         ST_X2: begin
            mul_a = $signed(34'(term_init));
            mul_b = $signed(34'(x2_tap));
         end
         ST_T1: begin
            mul_a = $signed(34'(v_tap));
            mul_b = $signed(34'(rec_sel));
         end
         ST_T2: begin
            mul_a = $signed(34'(q_tap));
            mul_b = $signed(34'(div_sel));
         end
         ST_T3: begin
            mul_a = $signed(34'(term_new));
            mul_b = $signed(34'(x2_ff));
         end
         ST_ACC: begin
            mul_a = 34'($signed(jfob_pkg::COEF_I[k_ff]));
            mul_b = 34'(cp_tap);
         end
         ST_AI: begin
            mul_a = 34'($signed(jfob_pkg::COEF_Q[k_ff]));
            mul_b = 34'(cp_ff);
         end
         ST_RND: begin
            mul_a = 34'(iv_in);
            mul_b = 34'(iv_in);
         end
         ST_P1: begin
            mul_a = 34'(qv_ff);
            mul_b = 34'(qv_ff);
         end
         ST_NORM: begin
            mul_a = $signed(34'(m_ff));
            mul_b = $signed(34'(m_ff));
         end
         ST_LOG: begin
            if (b_ff == 4'd15) begin
               mul_a = 34'(lg);
               mul_b = 34'(jfob_pkg::DB_PER_LOG2);
            end else begin
               mul_a = $signed(34'(m_new));
               mul_b = $signed(34'(m_new));
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      link_in     = link_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      use_sin_in  = use_sin_ff;
      neg_in      = neg_ff;
      x2_in       = x2_ff;
      v_in        = v_ff;
      q_in        = q_ff;
      sum_in      = sum_ff;
      cp_in       = cp_ff;
      acc_i_in    = acc_i_ff;
      acc_q_in    = acc_q_ff;
      iv_in       = iv_ff;
      qv_in       = qv_ff;
      p1_in       = p1_ff;
      m_in        = m_ff;
      e_in        = e_ff;
      b_in        = b_ff;
      frac_in     = frac_ff;
      db_in       = db_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_i_in    = rsp_i_ff;
      rsp_q_in    = rsp_q_ff;
      rsp_db_in   = rsp_db_ff;
      rsp_link_in = rsp_link_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_link_ok && (req_ch.command == jfob_pkg::CMD_ADVANCE)) begin
               link_in  = req_ch.link;
               k_in     = '0;
               acc_i_in = '0;
               acc_q_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_INC;
         ST_INC: begin
            use_sin_in = ang[30] ^ ang_big;
            neg_in     = ang[31] ^ ang[30];
            state_in   = ST_X;
         end
         ST_X: begin
            v_in     = x_tap;   // x held for the sine series start
            state_in = ST_X2;
         end
         ST_X2: begin
            x2_in    = x2_tap;
            sum_in   = 33'(term_init);
            n_in     = TERM_ONE;
            state_in = ST_T1;
         end
         ST_T1: begin
            v_in     = v_tap;
            state_in = ST_T2;
         end
         ST_T2: begin
            q_in     = q_tap;
            state_in = ST_T3;
         end
         ST_T3: begin
            sum_in = n_ff[0] ? (sum_ff - 33'(term_new)) : (sum_ff + 33'(term_new));
            if (32'(n_ff) == jfob_pkg::TERMS) begin
               state_in = ST_ACC;
            end else begin
               n_in     = n_ff + TERM_ONE;
               state_in = ST_T1;
            end
         end
         ST_ACC: begin
            cp_in    = cp_tap;
            state_in = ST_AI;
         end
         ST_AI: begin
            acc_i_in = acc_i_ff + mul_p_ff[65:30];
            state_in = ST_AQ;
         end
         ST_AQ: begin
            acc_q_in = acc_q_ff + mul_p_ff[65:30];
            if (32'(k_ff) == jfob_pkg::OSC_COUNT) begin
               state_in = ST_RND;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RND: begin
            iv_in    = sat16(24'($signed(rnd_i[36:19])));
            qv_in    = sat16(24'($signed(rnd_q[36:19])));
            state_in = ST_P1;
         end
         ST_P1: begin
            p1_in    = mul_p_ff[31:0];
            state_in = ST_P2;
         end
         ST_P2: begin
            if (p_sum == 32'd0) begin
               db_in    = 16'sh8000;
               state_in = ST_OUT;
            end else if (p_sum[31]) begin
               m_in     = p_sum[31:1];
               e_in     = 5'd31;
               state_in = ST_NORM;
            end else begin
               m_in     = p_sum[30:0];
               e_in     = 5'd30;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (m_ff[30]) begin
               b_in     = '0;
               frac_in  = '0;
               state_in = ST_LOG;
            end else begin
               m_in = {m_ff[29:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         ST_LOG: begin
            frac_in = frac_new;
            m_in    = m_new;
            if (b_ff == 4'd15) begin
               state_in = ST_DB;
            end else begin
               b_in = b_ff + 4'd1;
            end
         end
         ST_DB: begin
            db_in    = sat16(db_r[47:24]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_i_in     = iv_ff;
               rsp_q_in     = qv_ff;
               rsp_db_in    = db_ff;
               rsp_link_in  = link_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         n_ff         <= TERM_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
      end
      link_ff     <= link_in;
      use_sin_ff  <= use_sin_in;
      neg_ff      <= neg_in;
      x2_ff       <= x2_in;
      v_ff        <= v_in;
      q_ff        <= q_in;
      sum_ff      <= sum_in;
      cp_ff       <= cp_in;
      acc_i_ff    <= acc_i_in;
      acc_q_ff    <= acc_q_in;
      iv_ff       <= iv_in;
      qv_ff       <= qv_in;
      p1_ff       <= p1_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      b_ff        <= b_in;
      frac_ff     <= frac_in;
      db_ff       <= db_in;
      rsp_i_ff    <= rsp_i_in;
      rsp_q_ff    <= rsp_q_in;
      rsp_db_ff   <= rsp_db_in;
      rsp_link_ff <= rsp_link_in;
      mul_p_ff    <= 68'(mul_a) * 68'(mul_b);
   end

   // phase store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         phase_mem[mem_wa] <= mem_wd;
      end
      ph_rd_ff <= phase_mem[rd_addr];
   end

   // per-entry valid bits stand in for the zero reset of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_vld_ff    <= '0;
         ph_rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            ph_vld_ff[mem_wa] <= 1'b1;
         end
         ph_rd_vld_ff <= ph_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jfob_pkg::LINKS; i++) begin
            step_ff[i] <= '0;
         end
      end else if (step_we) begin
         step_ff[req_ch.link[jfob_pkg::LINK_AW-1:0]] <= req_ch.value;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.in_phase   = rsp_i_ff;
   assign rsp_ch.quadrature = rsp_q_ff;
   assign rsp_ch.power_db   = rsp_db_ff;
   assign rsp_ch.link_out   = rsp_link_ff;

   `JFOB_ASSERT_SAME(a_term_index, state_ff == ST_T1,
      (n_ff != '0) && (32'(n_ff) <= jfob_pkg::TERMS), "series term index out of range")
   `JFOB_ASSERT_SAME(a_osc_index, state_ff != ST_IDLE,
      32'(k_ff) <= jfob_pkg::OSC_COUNT, "oscillator index out of range")
   `JFOB_ASSERT_SAME(a_norm_nonzero, state_ff == ST_NORM, m_ff != '0,
      "normalising a zero power")
   `JFOB_ASSERT_NEXT(a_last_osc, (state_ff == ST_AQ) && (32'(k_ff) == jfob_pkg::OSC_COUNT),
      state_ff == ST_RND, "oscillator walk did not end after the last one")
   `JFOB_ASSERT_SAME(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == ST_OUT),
      "result beat raised outside output state")

endmodule

/* bench/jakes_fading_oscillator_bank_top_tb.sv */
`timescale 1ns / 1ps

module jakes_fading_oscillator_bank_top_tb;

   typedef logic [jfob_pkg::CMD_W-1:0]   cmd_bits_type;
   typedef logic [jfob_pkg::LINK_W-1:0]  link_type;
   typedef logic [jfob_pkg::OSC_W-1:0]   osc_type;
   typedef logic [jfob_pkg::VALUE_W-1:0] value_type;

   // command code the block leaves unused
   localparam cmd_bits_type CMD_UNUSED = 2'd3;
   // extra drain wait after the wait for pending results
   localparam int DRAIN_CYCLES = 1000;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic clock;
   logic reset;

   jfob_req_if req_ch ();
   jfob_rsp_if rsp_ch ();

   jakes_fading_oscillator_bank_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   typedef struct {
      logic signed [jfob_pkg::OUT_W-1:0] in_phase;
      logic signed [jfob_pkg::OUT_W-1:0] quadrature;
      logic signed [jfob_pkg::OUT_W-1:0] power_db;
      link_type                          link_out;
   } fading_beat_type;

   // Scoreboard: holds its own copy of the phase and step stores and works out
   // each fading result as an advance beat is taken.
   class fading_scoreboard;
      logic [jfob_pkg::PHASE_BITS-1:0] phase_store [jfob_pkg::PHASE_DEPTH];
      value_type                       step_store [jfob_pkg::LINKS];
      fading_beat_type                 pending [$];
      int                              errors;

      function new();
         foreach (phase_store[i]) phase_store[i] = '0;
         foreach (step_store[i]) step_store[i] = '0;
         errors = 0;
      endfunction

      task report(string what);
         $display("mismatch @%0t: %s", $realtime, what);
         errors++;
      endtask

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // angle within an eighth of a turn, Q0.32 in, Q2.30 out
      function void series(logic [31:0] t, output longint c, output longint s);
         longint unsigned x, x2, tc, ts;
         x  = ({32'd0, t} * jfob_pkg::PI_Q30) >> 31;
         x2 = (x * x) >> 30;
         tc = 64'd1 << 30;
         ts = x;
         c  = longint'(tc);
         s  = longint'(ts);
         for (int n = 1; n <= 7; n++) begin
            tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               c -= longint'(tc);
               s -= longint'(ts);
            end else begin
               c += longint'(tc);
               s += longint'(ts);
            end
         end
      endfunction

      function void turn_trig(logic [31:0] a, output longint c, output longint s);
         logic [31:0] r;
         longint      c0, s0;
         r = {2'b00, a[29:0]};
         if (r <= 32'h2000_0000) series(r, c0, s0);
         else series(32'h4000_0000 - r, s0, c0);
         unique case (a[31:30])
            2'd0: begin c = c0;  s = s0;  end
            2'd1: begin c = -s0; s = c0;  end
            2'd2: begin c = -c0; s = -s0; end
            default: begin c = s0; s = -c0; end
         endcase
      endfunction

      function longint clip16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function fading_beat_type advance_link(link_type lk);
         fading_beat_type r;
         longint          acc_i, acc_q, cd, sd, cp, sp, cb, sb, ci, cq, iv, qv, lg, frac;
         longint unsigned sq_i, sq_q, sq_0, mag, inc, ang, p, m;
         logic [jfob_pkg::PHASE_BITS-1:0] ph;
         int              idx, e;
         acc_i = 0;
         acc_q = 0;
         sq_i  = root(longint'(2 * jfob_pkg::OSC_COUNT) << 56);
         sq_q  = root(longint'(2 * jfob_pkg::OSC_COUNT + 2) << 56);
         sq_0  = root(longint'(jfob_pkg::OSC_COUNT) << 56);
         for (int k = 0; k <= jfob_pkg::OSC_COUNT; k++) begin
            idx = lk * jfob_pkg::OSC_SLOTS + k;
            ang = (longint'(k) << 32) / (4 * jfob_pkg::OSC_COUNT + 2);
            turn_trig(ang[31:0], cd, sd);
            mag = (cd < 0) ? -cd : cd;
            inc = ({40'd0, step_store[lk]} * mag + (64'd1 << (jfob_pkg::INC_SH - 1)))
                  >> jfob_pkg::INC_SH;
            ph  = phase_store[idx];
            if (cd < 0) ph = ph - inc[jfob_pkg::PHASE_BITS-1:0];
            else ph = ph + inc[jfob_pkg::PHASE_BITS-1:0];
            phase_store[idx] = ph;
            turn_trig({ph, {(32 - jfob_pkg::PHASE_BITS){1'b0}}}, cp, sp);
            if (k == 0) begin
               ci = longint'((64'd1 << 58) / sq_0);
               cq = 0;
            end else begin
               ang = (longint'(k) << 32) / (2 * jfob_pkg::OSC_COUNT);
               turn_trig(ang[31:0], cb, sb);
               ci = (cb * (longint'(1) << 29)) / longint'(sq_i);
               cq = (sb * (longint'(1) << 29)) / longint'(sq_q);
            end
            acc_i += (ci * cp) >>> 30;
            acc_q += (cq * cp) >>> 30;
         end
         iv = clip16((acc_i + (longint'(1) << 18)) >>> 19);
         qv = clip16((acc_q + (longint'(1) << 18)) >>> 19);
         p  = iv * iv + qv * qv;
         if (p == 0) begin
            r.power_db = 16'sh8000;
         end else begin
            e = 0;
            while (e < 63 && (p >> (e + 1)) != 0) e++;
            m    = (e <= 30) ? (p << (30 - e)) : (p >> (e - 30));
            frac = 0;
            for (int b = 0; b < 16; b++) begin
               m    = (m * m) >> 30;
               frac = frac * 2;
               if (m >= (64'd1 << 31)) begin
                  frac = frac | 1;
                  m    = m >> 1;
               end
            end
            lg = (longint'(e) - 22) * 65536 + frac;
            r.power_db = 16'(clip16((lg * jfob_pkg::DB_PER_LOG2 + (longint'(1) << 23)) >>> 24));
         end
         r.in_phase   = 16'(iv);
         r.quadrature = 16'(qv);
         r.link_out   = lk;
         return r;
      endfunction

      function void note_request(cmd_bits_type cmd, link_type lk, osc_type osc,
                                 value_type val);
         if (lk >= jfob_pkg::LINKS) return;
         unique case (cmd)
            jfob_pkg::CMD_SET_STEP: step_store[lk] = val;
            jfob_pkg::CMD_LOAD_PHASE:
               if (osc <= jfob_pkg::OSC_COUNT)
                  phase_store[lk * jfob_pkg::OSC_SLOTS + osc] = val[jfob_pkg::PHASE_BITS-1:0];
            jfob_pkg::CMD_ADVANCE: pending.push_back(advance_link(lk));
            default: ;
         endcase
      endfunction

      task check_result(fading_beat_type got);
         fading_beat_type exp_b;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result beat for link %0d", got.link_out));
            return;
         end
         exp_b = pending.pop_front();
         if (got.in_phase !== exp_b.in_phase)
            report($sformatf("link %0d in_phase %0d, want %0d",
                             exp_b.link_out, got.in_phase, exp_b.in_phase));
         if (got.quadrature !== exp_b.quadrature)
            report($sformatf("link %0d quadrature %0d, want %0d",
                             exp_b.link_out, got.quadrature, exp_b.quadrature));
         if (got.power_db !== exp_b.power_db)
            report($sformatf("link %0d power_db %0d, want %0d",
                             exp_b.link_out, got.power_db, exp_b.power_db));
         if (got.link_out !== exp_b.link_out)
            report($sformatf("link_out %0d, want %0d", got.link_out, exp_b.link_out));
      endtask
   endclass

   fading_scoreboard fading_sb;
   int               send_gap_pct;   // chance of an idle cycle before a request beat
   int               recv_stall_pct; // chance the result side holds ready low
   int               cycle_count = 0;

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop should the block hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // both monitors sample before the edge's updates land
   always @(posedge clock) begin
      fading_beat_type got;
      if (!reset && req_ch.valid && req_ch.ready)
         fading_sb.note_request(req_ch.command, req_ch.link, req_ch.oscillator, req_ch.value);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.in_phase   = rsp_ch.in_phase;
         got.quadrature = rsp_ch.quadrature;
         got.power_db   = rsp_ch.power_db;
         got.link_out   = rsp_ch.link_out;
         fading_sb.check_result(got);
      end
   end

   // One request beat: idle cycles drawn one at a time, then hold valid until taken.
   task automatic send_beat(cmd_bits_type cmd, link_type lk, osc_type osc, value_type val);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.link       <= lk;
      req_ch.oscillator <= osc;
      req_ch.value      <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic end_burst();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed link sessions: set a step, load some phases, advance a
   // few ticks.  The rest is noise, including ignored loads and the unused code.
   task automatic random_traffic(int beats);
      int           sent;
      link_type     lk;
      cmd_bits_type cmd;
      osc_type      osc;
      sent = 0;
      while (sent < beats) begin
         lk = link_type'($urandom_range(jfob_pkg::LINKS - 1));
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(3) != 0) begin
               send_beat(jfob_pkg::CMD_SET_STEP, lk, osc_type'($urandom),
                         value_type'($urandom));
               sent++;
            end
            repeat ($urandom_range(jfob_pkg::OSC_SLOTS)) begin
               send_beat(jfob_pkg::CMD_LOAD_PHASE, lk,
                         osc_type'($urandom_range(jfob_pkg::OSC_COUNT)),
                         value_type'($urandom));
               sent++;
            end
            repeat ($urandom_range(4, 1)) begin
               send_beat(jfob_pkg::CMD_ADVANCE, lk, osc_type'($urandom),
                         value_type'($urandom));
               sent++;
            end
         end else begin
            cmd = cmd_bits_type'($urandom_range(3));
            osc = osc_type'($urandom_range(15));
            send_beat(cmd, lk, osc, value_type'($urandom));
            if (cmd != CMD_UNUSED
                && !(cmd == jfob_pkg::CMD_LOAD_PHASE && osc > jfob_pkg::OSC_COUNT)) sent++;
         end
      end
   endtask

   initial begin
      int wait_cycles;
      fading_sb         = new();
      send_gap_pct      = 0;
      recv_stall_pct    = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = jfob_pkg::CMD_SET_STEP;
      req_ch.link       = '0;
      req_ch.oscillator = '0;
      req_ch.value      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: untouched link straight after reset
      send_beat(jfob_pkg::CMD_ADVANCE, 4'd0, 4'd0, 24'd0);
      // every oscillator at a quarter turn with no step gives zero power
      send_beat(jfob_pkg::CMD_SET_STEP, 4'd1, 4'd0, 24'd0);
      for (int k = 0; k <= jfob_pkg::OSC_COUNT; k++)
         send_beat(jfob_pkg::CMD_LOAD_PHASE, 4'd1, osc_type'(k), 24'h00_4000);
      send_beat(jfob_pkg::CMD_ADVANCE, 4'd1, 4'd15, 24'hFF_FFFF);
      // full-scale step and phase, with the bits above the phase width set
      send_beat(jfob_pkg::CMD_SET_STEP, 4'd15, 4'd15, 24'hFF_FFFF);
      send_beat(jfob_pkg::CMD_LOAD_PHASE, 4'd15, 4'd8, 24'hFF_FFFF);
      send_beat(jfob_pkg::CMD_LOAD_PHASE, 4'd15, 4'd0, 24'hAB_0000);
      // oscillator index past the last one: ignored
      send_beat(jfob_pkg::CMD_LOAD_PHASE, 4'd15, 4'd9, 24'h00_1234);
      send_beat(jfob_pkg::CMD_LOAD_PHASE, 4'd15, 4'd15, 24'h00_8000);
      // unused command code: ignored
      send_beat(CMD_UNUSED, 4'd15, 4'd3, 24'h12_3456);
      send_beat(jfob_pkg::CMD_ADVANCE, 4'd15, 4'd0, 24'd0);
      send_beat(jfob_pkg::CMD_ADVANCE, 4'd15, 4'd0, 24'd0);
      send_beat(jfob_pkg::CMD_SET_STEP, 4'd7, 4'd0, 24'h00_0001);
      send_beat(jfob_pkg::CMD_ADVANCE, 4'd7, 4'd0, 24'd0);
      end_burst();

      // sender sparse gaps, receiver mostly stalled
      send_gap_pct   = 21;
      recv_stall_pct = 77;
      random_traffic(330);
      // the other way round
      send_gap_pct   = 77;
      recv_stall_pct = 21;
      random_traffic(330);
      // flat out
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      random_traffic(330);
      end_burst();

      wait_cycles = 0;
      while (fading_sb.pending.size() != 0 && wait_cycles < 200_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fading_sb.pending.size() != 0)
         fading_sb.report($sformatf("%0d results never arrived", fading_sb.pending.size()));

      if (fading_sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/jfob_pkg.sv
rtl/core/jfob_req_if.sv
rtl/core/jfob_rsp_if.sv
rtl/core/jakes_fading_oscillator_bank_top.sv
bench/jakes_fading_oscillator_bank_top_tb.sv
